>>> rtl/core/i32div_pkg.sv
// ----------------------------------------------------------------------------
// i32div_pkg: shared definitions for the 32-bit integer divider
// Operand width, iteration counter width, sequencer state type and request struct.
// ----------------------------------------------------------------------------
package i32div_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_WIDTH  = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } div_state_e;

  // Request from the sequencer to the shift-subtract unit.
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

endpackage

>>> rtl/core/i32div_core.sv
// ----------------------------------------------------------------------------
// i32div_core: restoring shift-subtract unsigned divider
// One quotient bit per cycle; the results hold after done until restarted.
// ----------------------------------------------------------------------------
module i32div_core
  import i32div_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output logic     done_o,
  output word_t    quotient_o,
  output word_t    remainder_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;
  word_t                rem_q, rem_d;
  word_t                quo_q, quo_d;
  word_t                dvs_q, dvs_d;

  logic                 carry;
  word_t                shifted;
  logic [DATA_WIDTH:0]  diff;
  logic                 take;

  // The quotient register also holds the dividend bits still to be brought
  // down; they leave at the top as quotient bits enter at the bottom.
  assign carry   = rem_q[DATA_WIDTH-1];
  assign shifted = {rem_q[DATA_WIDTH-2:0], quo_q[DATA_WIDTH-1]};
  assign diff    = {carry, shifted} - {1'b0, dvs_q};
  assign take    = carry | ~diff[DATA_WIDTH];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_WIDTH'(DATA_WIDTH - 1);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = take ? diff[DATA_WIDTH-1:0] : shifted;
      quo_d = {quo_q[DATA_WIDTH-2:0], take};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> rtl/core/int32_divider_signed_unsigned_unit.sv
// ----------------------------------------------------------------------------
// int32_divider_signed_unsigned_unit: 32-bit signed and unsigned divider
// Streams in dividend, divisor and mode; streams out quotient and remainder.
// ----------------------------------------------------------------------------
// An accepted word starts the shift-subtract unit, which resolves one quotient
// bit per cycle; its registered done flag then loads the sign-fixed result into
// the output stage once that is free, and the sequencer returns to idle.
// The input side is ready again while a finished result still waits.
// Reset (rst_ni low, asynchronous) empties the sequencer and the output stage.
// ----------------------------------------------------------------------------
module int32_divider_signed_unsigned_unit
  import i32div_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] dividend, [63:32] divisor
  input  logic        s_axis_tuser_i,   // [0] mode: 0 unsigned, 1 signed
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // [31:0] quotient, [63:32] remainder
);

  div_state_e state_q, state_d;
  div_req_t   req;
  logic       core_done;
  word_t      core_quo, core_rem;

  // Sign and special-case flags captured with the word.
  logic       qneg_q, qneg_d;
  logic       rneg_q, rneg_d;
  logic       zero_q, zero_d;

  logic       out_valid_q, out_valid_d;
  word_t      out_quo_q, out_rem_q;
  logic       out_load;

  word_t      in_dividend, in_divisor;
  logic       in_signed, a_neg, b_neg, accept;
  word_t      fix_quo, fix_rem;

  assign in_dividend = s_axis_tdata_i[31:0];
  assign in_divisor  = s_axis_tdata_i[63:32];
  assign in_signed   = s_axis_tuser_i;
  assign a_neg       = in_signed & in_dividend[DATA_WIDTH-1];
  assign b_neg       = in_signed & in_divisor[DATA_WIDTH-1];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  // The unit always divides magnitudes. With a zero divisor it subtracts
  // nothing, so the remainder comes back as the dividend magnitude and the
  // sign fix-up restores the dividend exactly; only the quotient is forced.
  assign req.start    = accept;
  assign req.dividend = a_neg ? (~in_dividend + 1'b1) : in_dividend;
  assign req.divisor  = b_neg ? (~in_divisor + 1'b1) : in_divisor;

  i32div_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .done_o      (core_done),
    .quotient_o  (core_quo),
    .remainder_o (core_rem)
  );

  // Sign fix-up. The most negative value over minus one wraps naturally here.
  assign fix_quo = zero_q ? '0 : (qneg_q ? (~core_quo + 1'b1) : core_quo);
  assign fix_rem = rneg_q ? (~core_rem + 1'b1) : core_rem;

  always_comb begin
    state_d     = state_q;
    qneg_d      = qneg_q;
    rneg_d      = rneg_q;
    zero_d      = zero_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          qneg_d  = a_neg ^ b_neg;
          rneg_d  = a_neg;
          zero_d  = (in_divisor == '0);
          state_d = ST_RUN;
        end
      end
      ST_RUN, ST_HOLD: begin
        if (core_done || state_q == ST_HOLD) begin
          // The output stage takes the result once its previous word has gone.
          if (!out_valid_q || m_axis_tready_i) begin
            out_load    = 1'b1;
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      qneg_q      <= 1'b0;
      rneg_q      <= 1'b0;
      zero_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      qneg_q      <= qneg_d;
      rneg_q      <= rneg_d;
      zero_q      <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_quo_q <= fix_quo;
      out_rem_q <= fix_rem;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_rem_q, out_quo_q};

  // The unit only finishes while the sequencer is waiting for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> (state_q == ST_RUN))
    else $error("divider unit finished outside a running division");

  // An accepted word always starts a division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RUN))
    else $error("accepted word did not start a division");

  // A zero divisor yields a zero quotient.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && zero_q) |=> (m_axis_tdata_o[31:0] == '0))
    else $error("divide by zero gave a nonzero quotient");

  // A result is never loaded over a word the sink has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("output word overwritten before it was taken");

endmodule

>>> tb/int32_divider_checker.sv
// ----------------------------------------------------------------------------
// int32_divider_checker: quotient and remainder checker for the divider
// Watches both stream channels, works out the quotient and remainder of every
// accepted word and compares each returned word with the oldest one waiting.
// ----------------------------------------------------------------------------
module int32_divider_checker
  import i32div_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] dividend, [63:32] divisor
  input  logic        s_axis_tuser_i,   // [0] mode: 0 unsigned, 1 signed
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [63:0] m_axis_tdata_i,   // [31:0] quotient, [63:32] remainder
  output int          outstanding_o,
  output int          mismatches_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    word_t quotient;
    word_t remainder;
  } quot_rem_t;

  quot_rem_t quot_rem_queue[$];
  int        mismatches = 0;

  // Signed mode works on magnitudes and fixes the signs afterwards, so the
  // most negative dividend over minus one wraps back onto itself.
  function automatic quot_rem_t divide_words(word_t dividend, word_t divisor,
                                             logic is_signed);
    quot_rem_t res;
    logic      dividend_neg;
    logic      divisor_neg;
    word_t     dividend_mag;
    word_t     divisor_mag;
    if (divisor == '0) begin
      res.quotient  = '0;
      res.remainder = dividend;
      return res;
    end
    dividend_neg  = is_signed & dividend[DATA_WIDTH-1];
    divisor_neg   = is_signed & divisor[DATA_WIDTH-1];
    dividend_mag  = dividend_neg ? word_t'(-dividend) : dividend;
    divisor_mag   = divisor_neg ? word_t'(-divisor) : divisor;
    res.quotient  = dividend_mag / divisor_mag;
    res.remainder = dividend_mag % divisor_mag;
    if (dividend_neg != divisor_neg) res.quotient = word_t'(-res.quotient);
    if (dividend_neg) res.remainder = word_t'(-res.remainder);
    return res;
  endfunction

  always @(posedge clk_i) begin
    quot_rem_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        quot_rem_queue.push_back(divide_words(s_axis_tdata_i[31:0],
                                              s_axis_tdata_i[63:32],
                                              s_axis_tuser_i));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (quot_rem_queue.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h",
                   $time, m_axis_tdata_i);
          mismatches++;
        end else begin
          want = quot_rem_queue.pop_front();
          if (m_axis_tdata_i[31:0] !== want.quotient) begin
            $display("%0t: quotient mismatch, expected %h, actual %h",
                     $time, want.quotient, m_axis_tdata_i[31:0]);
            mismatches++;
          end
          if (m_axis_tdata_i[63:32] !== want.remainder) begin
            $display("%0t: remainder mismatch, expected %h, actual %h",
                     $time, want.remainder, m_axis_tdata_i[63:32]);
            mismatches++;
          end
        end
      end
    end
  end

  assign outstanding_o = quot_rem_queue.size();
  assign mismatches_o  = mismatches;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the 32-bit signed and unsigned divider
// Drives directed corner cases and then randomised operand words into the
// divider with random idling on both sides; a checker beside it does the
// comparison and reports its mismatch count back for the final verdict.
// ----------------------------------------------------------------------------
module tb
  import i32div_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_UNSIGNED = 1'b0;
  localparam logic MODE_SIGNED   = 1'b1;

  // Number of random words after the directed part, and how many of the last
  // ones go through with no idling on either side.
  localparam int RANDOM_WORDS = 450;
  localparam int QUIET_WORDS  = 60;

  // A word needs its division plus, at worst, the longest sender gap and
  // receiver stall on top. The limit allows many times that in which neither
  // channel moves a word.
  localparam int IDLE_LIMIT = 2000;

  localparam word_t MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam word_t MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t ALL_ONES = '1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  int          outstanding;
  int          mismatches;

  // Percentage chances that the sender starts a gap before a word, or that
  // the receiver starts a stall; both are changed per phase of the run.
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int32_divider_signed_unsigned_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  int32_divider_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .outstanding_o   (outstanding),
    .mismatches_o    (mismatches)
  );

  // The receiver stalls in bursts of random length. The burst counter is
  // private to this process, so a single nonblocking write per edge suffices.
  always @(posedge clk_i) begin
    int stall_left;
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(99, 0) < stall_pct) begin
      stall_left = $urandom_range(10, 1) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Presents one word and holds it until the divider takes it. It is always
  // entered straight after a rising edge, and returns on the accepting edge,
  // so a following word can keep tvalid high without lowering it.
  task automatic send_word(input word_t dividend, input word_t divisor,
                           input logic mode);
    s_axis_tdata  <= {divisor, dividend};
    s_axis_tuser  <= mode;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Holds the sender off until every word sent so far has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Operands lean towards the interesting corners: small values of either
  // sign, the extremes, powers of two and values of random bit length, with
  // a fair share of fully random patterns so that every bit toggles.
  function automatic word_t pick_operand();
    word_t v;
    case ($urandom_range(7, 0))
      0: v = word_t'($urandom_range(255, 0));
      1: v = word_t'(-$urandom_range(256, 1));
      2: begin
        case ($urandom_range(4, 0))
          0: v = '0;
          1: v = word_t'(1);
          2: v = ALL_ONES;
          3: v = MOST_NEG;
          default: v = MOST_POS;
        endcase
      end
      3: v = word_t'(1) << $urandom_range(DATA_WIDTH - 1, 0);
      4: v = word_t'($urandom()) >> $urandom_range(DATA_WIDTH - 1, 0);
      default: v = word_t'($urandom());
    endcase
    return v;
  endfunction

  // A zero divisor comes up now and then on purpose; beyond that the divisor
  // is often made much shorter than the dividend to get large quotients.
  function automatic word_t pick_divisor();
    word_t v;
    if ($urandom_range(99, 0) < 4) begin
      v = '0;
    end else if ($urandom_range(3, 0) == 0) begin
      v = word_t'($urandom_range(15, 1));
      if ($urandom_range(1, 0) != 0) v = word_t'(-v);
    end else begin
      v = pick_operand();
    end
    return v;
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extremes in both modes, division by zero, the most
    // negative value over minus one and every sign combination.
    send_word('0, word_t'(1), MODE_UNSIGNED);
    send_word(ALL_ONES, word_t'(1), MODE_UNSIGNED);
    send_word(ALL_ONES, ALL_ONES, MODE_UNSIGNED);
    send_word(word_t'(7), '0, MODE_UNSIGNED);
    send_word(word_t'(7), '0, MODE_SIGNED);
    send_word(MOST_NEG, '0, MODE_SIGNED);
    send_word('0, '0, MODE_SIGNED);
    send_word(MOST_NEG, ALL_ONES, MODE_SIGNED);
    send_word(MOST_NEG, ALL_ONES, MODE_UNSIGNED);
    send_word(word_t'(-7), word_t'(2), MODE_SIGNED);
    send_word(word_t'(7), word_t'(-2), MODE_SIGNED);
    send_word(word_t'(-7), word_t'(-2), MODE_SIGNED);
    send_word(word_t'(7), word_t'(2), MODE_SIGNED);
    send_word(MOST_POS, MOST_NEG, MODE_SIGNED);
    send_word(MOST_NEG, MOST_NEG, MODE_SIGNED);
    send_word(MOST_NEG, word_t'(1), MODE_SIGNED);
    send_word(ALL_ONES, ALL_ONES, MODE_SIGNED);
    send_word(MOST_POS, word_t'(1), MODE_SIGNED);
    send_word(word_t'(5), ALL_ONES, MODE_UNSIGNED);
    send_word(word_t'(1), MOST_NEG, MODE_UNSIGNED);
    send_word(32'hDEADBEEF, word_t'(16), MODE_UNSIGNED);
    send_word(32'hDEADBEEF, word_t'(16), MODE_SIGNED);
    send_word(word_t'(100), word_t'(7), MODE_SIGNED);

    // Let everything come back before the random part starts.
    drain_results();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Each stretch of 75 words gets its own amount of idling, sometimes
      // none, and the closing stretch runs without any at all.
      if (i >= RANDOM_WORDS - QUIET_WORDS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (i % 75 == 0) begin
        case ($urandom_range(3, 0))
          0: gap_pct = 0;
          1: gap_pct = 10;
          2: gap_pct = 30;
          default: gap_pct = 60;
        endcase
        case ($urandom_range(3, 0))
          0: stall_pct = 0;
          1: stall_pct = 10;
          2: stall_pct = 30;
          default: stall_pct = 60;
        endcase
      end

      if (i == RANDOM_WORDS / 2) begin
        drain_results();
      end else if ($urandom_range(99, 0) < gap_pct) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(10, 1)) @(posedge clk_i);
      end
      send_word(pick_operand(), pick_divisor(), logic'($urandom_range(1, 0)));
    end

    // The last accepted word is only counted by the checker on the edge the
    // sender returned on, so the wait does not look before a later edge.
    drain_results();
    repeat (40) @(posedge clk_i);

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog: counts cycles after reset in which neither channel moves a
  // word, and ends the run once that count reaches the limit.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb failed");
    $finish;
  end

endmodule
